>>> sv/fqd_pkg.sv
package fqd_pkg;

  // Queue geometry.
  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);

  // Command codes.
  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FIN
  } state_t;

  // Command handed to the sequencer.
  typedef struct packed {
    logic [1:0]           cmd;
    logic [KEY_WIDTH-1:0] key;
  } req_t;

  // Result handed back by the sequencer.
  typedef struct packed {
    logic                 status;
    logic [KEY_WIDTH-1:0] key_out;
    logic [CW-1:0]        count;
  } res_t;

endpackage

>>> sv/fqd_ram.sv
module fqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/fqd_ctrl.sv
module fqd_ctrl import fqd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  input  logic res_free,
  output logic idle,
  output logic done,
  output res_t res
);

  state_t               state, state_next;
  logic [1:0]           cmd_r, cmd_r_next;
  logic [KEY_WIDTH-1:0] key_r, key_r_next;
  logic [AW-1:0]        idx, idx_next;
  logic [CW-1:0]        occ, occ_next;
  logic                 status_r, status_r_next;
  logic [KEY_WIDTH-1:0] kout, kout_next;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [KEY_WIDTH-1:0] rdata;
  logic [CW-1:0]        idx_inc;

  fqd_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Position after the current one, wide enough to hold the depth itself.
  assign idx_inc = CW'(idx) + CW'(1);

  // The read address looks one slot ahead while shifting the tail down.
  assign raddr = (state == ST_SH_RD) ? idx_inc[AW-1:0] : idx;

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_FIN) && res_free;

  assign res.status  = status_r;
  assign res.key_out = kout;
  assign res.count   = occ;

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
    end
    cmd_r    <= cmd_r_next;
    key_r    <= key_r_next;
    idx      <= idx_next;
    status_r <= status_r_next;
    kout     <= kout_next;
  end

  // Sequencer: append an enqueue directly; otherwise search with the shared comparator, then close the gap.
  always_comb begin
    state_next    = state;
    cmd_r_next    = cmd_r;
    key_r_next    = key_r;
    idx_next      = idx;
    occ_next      = occ;
    status_r_next = status_r;
    kout_next     = kout;
    we            = 1'b0;
    waddr         = idx;
    wdata         = rdata;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_r_next    = req.cmd;
          key_r_next    = req.key;
          idx_next      = '0;
          status_r_next = 1'b1;
          kout_next     = '0;
          state_next    = ST_FIN;
          if (req.cmd == CMD_ENQ) begin
            // Append at the tail in a single write.
            if (req.key != '0 && occ < CW'(DEPTH)) begin
              we            = 1'b1;
              waddr         = occ[AW-1:0];
              wdata         = req.key;
              occ_next      = occ + CW'(1);
              status_r_next = 1'b0;
            end
          end else if (req.cmd == CMD_DEQ) begin
            if (occ != '0) begin
              state_next = ST_RD;
            end
          end else if (req.cmd == CMD_DEL) begin
            if (req.key != '0 && occ != '0) begin
              state_next = ST_RD;
            end
          end
        end
      end

      ST_RD: begin
        state_next = ST_CMP;
      end

      ST_CMP: begin
        // A dequeue takes the head unconditionally.
        if (cmd_r == CMD_DEQ || rdata == key_r) begin
          status_r_next = 1'b0;
          if (cmd_r == CMD_DEQ) begin
            kout_next = rdata;
          end
          state_next = ST_SH_RD;
        end else if (idx_inc == occ) begin
          state_next = ST_FIN;
        end else begin
          idx_next   = idx_inc[AW-1:0];
          state_next = ST_RD;
        end
      end

      ST_SH_RD: begin
        if (idx_inc < occ) begin
          state_next = ST_SH_WR;
        end else begin
          occ_next   = occ - CW'(1);
          state_next = ST_FIN;
        end
      end

      ST_SH_WR: begin
        we         = 1'b1;
        waddr      = idx;
        wdata      = rdata;
        idx_next   = idx_inc[AW-1:0];
        state_next = ST_SH_RD;
      end

      ST_FIN: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/fifo_queue_with_delete.sv
// Bounded first-in first-out queue of nonzero keys with delete by value. Each
// accepted command beat (enqueue, dequeue or delete) returns exactly one result
// beat carrying the status, the dequeued key and the entry count. Keys sit
// compacted in a RAM with one read and one write port, oldest first, and one
// comparator walks them.
// An enqueue, a failing null or unused command, and any command on an empty
// queue go straight to the finish state; a dequeue or delete searches from
// the head and on a match shifts the later entries down, and every search
// step and every shift step needs one registered RAM read. cmd_stall is high
// while a command is being worked on; a finished result waits in the output
// register, so the next command is taken while it is still unread.
module fifo_queue_with_delete import fqd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  logic [1:0]           cmd,
  input  logic [KEY_WIDTH-1:0] key_in,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic                 status,
  output logic [KEY_WIDTH-1:0] key_out,
  output logic [CW-1:0]        count
);

  logic idle;
  logic done;
  logic start;
  logic res_free;
  req_t req;
  res_t res;
  res_t res_q;

  assign cmd_stall = !idle;
  assign start     = cmd_valid && idle;
  assign req.cmd   = cmd;
  assign req.key   = key_in;
  assign res_free  = !res_valid || !res_stall;

  fqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .res_free (res_free),
    .idle     (idle),
    .done     (done),
    .res      (res)
  );

  // Output register: holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (done) begin
      res_q <= res;
    end
  end

  assign status  = res_q.status;
  assign key_out = res_q.key_out;
  assign count   = res_q.count;

endmodule

>>> sv/fqd_checker.sv
module fqd_props import fqd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_stall,
  input logic                 res_valid,
  input logic                 res_stall,
  input logic                 status,
  input logic [KEY_WIDTH-1:0] key_out,
  input logic [CW-1:0]        count
);

  // A stalled result beat holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(key_out)
      && $stable(count))
    else $error("result beat changed while stalled");

  // A failed command never reports a key.
  a_fail_key: assert property (@(posedge clk) disable iff (rst)
    res_valid && status |-> key_out == '0)
    else $error("failure carries a nonzero key");

  // The count never exceeds the depth.
  a_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> count <= CW'(DEPTH))
    else $error("count beyond depth");

  // Every accepted command leaves the block busy in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command beat not followed by busy");

endmodule

bind fifo_queue_with_delete fqd_props u_fqd_props (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .status    (status),
  .key_out   (key_out),
  .count     (count)
);

>>> verif/fqd_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the delete-capable queue, keeps its own copy of
// the queue contents and checks every result beat against the oldest
// outstanding prediction.
module fqd_checker import fqd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic                 cmd_stall,
  input  logic [1:0]           cmd,
  input  logic [KEY_WIDTH-1:0] key_in,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  logic                 status,
  input  logic [KEY_WIDTH-1:0] key_out,
  input  logic [CW-1:0]        count,
  output int                   errors,
  output int                   pending,
  output int                   checked
);

  // Shadow of the queue, oldest key at index 0.
  logic [KEY_WIDTH-1:0] held[$];
  // Results predicted for accepted commands, oldest first.
  res_t                 awaited[$];
  res_t                 want;
  int                   faults = 0;
  int                   seen   = 0;

  assign errors  = faults;
  assign checked = seen;

  initial pending = 0;

  // Applies one command to the shadow queue and returns the result it earns.
  function automatic res_t queue_after_cmd(input logic [1:0] op,
                                           input logic [KEY_WIDTH-1:0] k);
    res_t r;
    int   spot;
    r.status  = 1'b1;
    r.key_out = '0;
    spot      = -1;
    case (op)
      CMD_ENQ: begin
        if (k != '0 && held.size() < DEPTH) begin
          held.push_back(k);
          r.status = 1'b0;
        end
      end
      CMD_DEQ: begin
        if (held.size() > 0) begin
          r.key_out = held.pop_front();
          r.status  = 1'b0;
        end
      end
      CMD_DEL: begin
        // Only the oldest matching entry goes; the rest keep their order.
        if (k != '0) begin
          for (int i = 0; i < held.size(); i++)
            if (spot < 0 && held[i] == k) spot = i;
          if (spot >= 0) begin
            held.delete(spot);
            r.status = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.count = CW'(held.size());
    return r;
  endfunction

  // Predict on every accepted command beat and compare on every result beat.
  always @(posedge clk) begin
    if (rst) begin
      held.delete();
      awaited.delete();
    end else begin
      if (cmd_valid && !cmd_stall)
        awaited.push_back(queue_after_cmd(cmd, key_in));
      if (res_valid && !res_stall) begin
        seen++;
        if (awaited.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("check: result beat %0d arrived with nothing expected", seen);
        end else begin
          want = awaited.pop_front();
          if (status !== want.status || key_out !== want.key_out ||
              count !== want.count) begin
            faults++;
            if (faults <= 10)
              $display("check: beat %0d expected %0b %h %0d, got %0b %h %0d",
                       seen, want.status, want.key_out, want.count,
                       status, key_out, count);
          end
        end
      end
    end
    pending <= awaited.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the delete-capable queue. The checker beside the
// block does all prediction and comparison.
module tb;
  import fqd_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic [1:0]           cmd       = CMD_ENQ;
  logic [KEY_WIDTH-1:0] key_in    = '0;
  logic                 res_stall = 1'b0;
  logic                 cmd_stall;
  logic                 res_valid;
  logic                 status;
  logic [KEY_WIDTH-1:0] key_out;
  logic [CW-1:0]        count;

  int errors;
  int pending;
  int checked;

  // Idling plan per phase, in percent of cycles.
  int idle_by_phase[4]  = '{0, 53, 0, 23};
  int stall_by_phase[4] = '{0, 0, 53, 23};
  int idle_pct  = 0;
  int stall_pct = 0;

  // Accepted command beats per command code.
  int sent[4] = '{0, 0, 0, 0};
  // A handful of keys reused often so that deletes find matches.
  logic [KEY_WIDTH-1:0] key_pool[8];

  fifo_queue_with_delete i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .key_in    (key_in),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .key_out   (key_out),
    .count     (count)
  );

  fqd_checker i_check (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .key_in    (key_in),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .key_out   (key_out),
    .count     (count),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The result side stalls at random according to the current phase.
  always @(posedge clk) begin
    res_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Offers one command beat, after an optional idle gap, and waits until it is taken.
  task automatic send(input logic [1:0] op, input logic [KEY_WIDTH-1:0] k);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= op;
    key_in    <= k;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent[op]++;
  endtask

  // Holds the sender back until every predicted result has been seen.
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_WIDTH-1:0] pick_key();
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  initial begin
    int roll;
    int fill_mode;
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = $urandom();
      if (key_pool[i] == '0) key_pool[i] = 1;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: failures on an empty queue, then deletes at the head, in the middle and at the tail.
    send(CMD_DEQ, '0);
    send(CMD_DEL, 32'h0000_0001);
    send(CMD_ENQ, '0);
    send(CMD_NONE, 32'hFFFF_FFFF);
    send(CMD_ENQ, 32'hFFFF_FFFF);
    send(CMD_ENQ, 32'h0000_0001);
    send(CMD_ENQ, 32'hA5A5_5A5A);
    send(CMD_ENQ, 32'h0000_0001);
    send(CMD_DEL, 32'h0000_0001);
    send(CMD_DEL, 32'h1234_5678);
    send(CMD_DEL, '0);
    send(CMD_DEL, 32'hFFFF_FFFF);
    send(CMD_DEL, 32'h0000_0001);
    send(CMD_DEQ, 32'hFFFF_FFFF);

    // Directed: fill to the brim, overflow, then delete at full and at the tail.
    for (int i = 0; i < DEPTH; i++) send(CMD_ENQ, key_pool[i % 8]);
    send(CMD_ENQ, 32'h8000_0000);
    send(CMD_DEL, key_pool[7]);
    send(CMD_ENQ, 32'h8000_0000);
    send(CMD_DEL, 32'h8000_0000);

    // Random: idle/stall phases, each opened by a full drain; the mix drifts
    // between filling and emptying so that both boundaries are reached.
    fill_mode = 1;
    for (int n = 0; n < 500; n++) begin
      if (n % 125 == 0) begin
        drain();
        idle_pct  = idle_by_phase[n / 125];
        stall_pct = stall_by_phase[n / 125];
      end
      if (n % 40 == 0) fill_mode = $urandom_range(1);
      roll = $urandom_range(99);
      if (roll < 2)
        send(CMD_NONE, $urandom());
      else if (roll < 4)
        send(CMD_ENQ, '0);
      else if (roll < 6)
        send(CMD_DEL, '0);
      else begin
        roll = $urandom_range(99);
        if (roll < (fill_mode ? 60 : 20))
          send(CMD_ENQ, pick_key());
        else if (roll < (fill_mode ? 75 : 60))
          send(CMD_DEQ, $urandom());
        else
          send(CMD_DEL, pick_key());
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("tb: %0d commands: %0d enqueue, %0d dequeue, %0d delete, %0d unused",
             sent[0] + sent[1] + sent[2] + sent[3], sent[0], sent[1], sent[2], sent[3]);
    $display("tb: %0d result beats checked over four idling phases, %0d mismatches",
             checked, errors);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

>>> sim.f
sv/fqd_pkg.sv
sv/fqd_ram.sv
sv/fqd_ctrl.sv
sv/fifo_queue_with_delete.sv
sv/fqd_checker.sv
verif/fqd_checker.sv
verif/tb.sv
